### src/spt_pkg.sv
// Shared types, constants and functions of the stride prefetch table.
`default_nettype none

package spt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W        = 32;

    localparam logic [ADDR_W-1:0] REGION_MASK_RESET = 32'hFFFF_F000;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [1:0] {
        CONF_INITIAL   = 2'd0,
        CONF_TRANSIENT = 2'd1,
        CONF_STEADY    = 2'd2,
        CONF_NOPRED    = 2'd3
    } t_conf;

    typedef enum logic [0:0] {
        CMD_ACCESS   = 1'b0,
        CMD_COMPLETE = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_REQ   = 2'd1,
        S_CMP   = 2'd2,
        S_WRITE = 2'd3
    } t_state;

    typedef enum logic [1:0] {
        OP_COMPLETE = 2'd0,
        OP_HIT      = 2'd1,
        OP_INSERT   = 2'd2
    } t_op;

    typedef struct packed {
        t_addr tag;
        t_addr last_addr;
        t_addr stride;
        t_conf conf;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic load;
        logic rd_en;
        logic idx_inc;
        logic exec;
        t_op  op;
    } t_ctrl_cmd;

    typedef struct packed {
        logic cmd_complete;
        logic table_empty;
        logic tag_hit;
        logic scan_last;
    } t_dp_status;

    function automatic t_conf next_conf(input t_conf cur, input logic same);
        t_conf res;
        case (cur)
            CONF_INITIAL:   res = CONF_TRANSIENT;
            CONF_TRANSIENT: res = same ? CONF_STEADY : CONF_NOPRED;
            CONF_STEADY:    res = same ? CONF_STEADY : CONF_INITIAL;
            CONF_NOPRED:    res = same ? CONF_TRANSIENT : CONF_NOPRED;
            default:        res = CONF_NOPRED;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

### src/spt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module spt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/spt_ctrl.sv
// Controller state machine that sequences the table scan and the update.
`default_nettype none

module spt_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire spt_pkg::t_dp_status i_status,
    output spt_pkg::t_ctrl_cmd       o_cmd
);

    spt_pkg::t_state r_state, n_state;
    spt_pkg::t_op    r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spt_pkg::S_IDLE;
            r_op    <= spt_pkg::OP_COMPLETE;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        case (r_state)
            spt_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_status.cmd_complete) begin
                        n_op    = spt_pkg::OP_COMPLETE;
                        n_state = spt_pkg::S_WRITE;
                    end else if (i_status.table_empty) begin
                        n_op    = spt_pkg::OP_INSERT;
                        n_state = spt_pkg::S_WRITE;
                    end else begin
                        n_state = spt_pkg::S_REQ;
                    end
                end
            end
            spt_pkg::S_REQ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = spt_pkg::S_CMP;
            end
            spt_pkg::S_CMP: begin
                if (i_status.tag_hit) begin
                    n_op    = spt_pkg::OP_HIT;
                    n_state = spt_pkg::S_WRITE;
                end else if (i_status.scan_last) begin
                    n_op    = spt_pkg::OP_INSERT;
                    n_state = spt_pkg::S_WRITE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = spt_pkg::S_REQ;
                end
            end
            spt_pkg::S_WRITE: begin
                o_cmd.exec = 1'b1;
                o_cmd.op   = r_op;
                n_state    = spt_pkg::S_IDLE;
            end
            default: begin
                n_state = spt_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != spt_pkg::S_IDLE);

endmodule

`default_nettype wire

### src/spt_datapath.sv
// Datapath: entry RAM, fill count, replace pointer, pending prefetch and results.
`default_nettype none

module spt_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [31:0]         i_cfg_wdata,
    input  wire logic                i_command,
    input  wire logic [31:0]         i_access_address,
    input  wire spt_pkg::t_ctrl_cmd  i_cmd,
    output spt_pkg::t_dp_status      o_status,
    output logic                     o_result_valid,
    output logic                     o_prefetch_pending,
    output logic [31:0]              o_prefetch_address,
    output logic [1:0]               o_entry_state
);

    spt_pkg::t_addr  r_mask;
    spt_pkg::t_addr  r_addr;
    spt_pkg::t_addr  r_stride;
    spt_pkg::t_idx   r_idx;
    spt_pkg::t_idx   r_rptr;
    spt_pkg::t_cnt   r_count;
    logic            r_pend_flag;
    spt_pkg::t_addr  r_pend_addr;
    spt_pkg::t_conf  r_state_out;
    logic            r_out_valid;

    spt_pkg::t_entry rd_entry;
    logic [spt_pkg::ENTRY_W-1:0] rd_data;
    spt_pkg::t_entry wr_entry;
    spt_pkg::t_idx   wr_addr;
    logic            wr_en;
    spt_pkg::t_conf  hit_conf;
    spt_pkg::t_idx   rptr_next;

    spt_ram #(
        .WIDTH (spt_pkg::ENTRY_W),
        .DEPTH (spt_pkg::TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_entry),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    assign rd_entry = spt_pkg::t_entry'(rd_data);

    // Entries are filled in order from index zero, so the valid ones are those below the count.
    assign o_status.cmd_complete = (i_command == spt_pkg::CMD_COMPLETE);
    assign o_status.table_empty  = (r_count == '0);
    assign o_status.tag_hit      = (rd_entry.tag == (r_addr & r_mask));
    assign o_status.scan_last    = (spt_pkg::CNT_W'(r_idx) == (r_count - spt_pkg::CNT_W'(1)));

    assign hit_conf  = spt_pkg::next_conf(rd_entry.conf, r_stride == rd_entry.stride);
    assign rptr_next = (r_rptr == spt_pkg::IDX_W'(spt_pkg::TABLE_ENTRIES - 1)) ?
                       '0 : r_rptr + spt_pkg::IDX_W'(1);

    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_entry = rd_entry;
        if (i_cmd.exec) begin
            case (i_cmd.op)
                spt_pkg::OP_HIT: begin
                    wr_en              = 1'b1;
                    wr_addr            = r_idx;
                    wr_entry.tag       = rd_entry.tag;
                    wr_entry.last_addr = r_addr;
                    wr_entry.stride    = r_stride;
                    wr_entry.conf      = hit_conf;
                end
                spt_pkg::OP_INSERT: begin
                    wr_en              = 1'b1;
                    wr_addr            = r_rptr;
                    wr_entry.tag       = r_addr & r_mask;
                    wr_entry.last_addr = r_addr;
                    wr_entry.stride    = '0;
                    wr_entry.conf      = spt_pkg::CONF_INITIAL;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // The stride is registered while the scan waits on the RAM, and the RAM output
    // holds through the update cycle, so the update sees a settled value.
    always_ff @(posedge i_clk) begin
        r_stride <= r_addr - rd_entry.last_addr;
        if (i_cmd.load) begin
            r_addr <= i_access_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= spt_pkg::REGION_MASK_RESET;
            r_idx       <= '0;
            r_rptr      <= '0;
            r_count     <= '0;
            r_pend_flag <= 1'b0;
            r_pend_addr <= '0;
            r_state_out <= spt_pkg::CONF_INITIAL;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.exec;
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + spt_pkg::IDX_W'(1);
            end
            if (i_cmd.exec) begin
                case (i_cmd.op)
                    spt_pkg::OP_COMPLETE: begin
                        r_pend_flag <= 1'b0;
                        r_state_out <= spt_pkg::CONF_INITIAL;
                    end
                    spt_pkg::OP_HIT: begin
                        r_state_out <= hit_conf;
                        if (!r_pend_flag && hit_conf == spt_pkg::CONF_STEADY) begin
                            r_pend_flag <= 1'b1;
                            r_pend_addr <= r_addr + r_stride;
                        end
                    end
                    spt_pkg::OP_INSERT: begin
                        r_state_out <= spt_pkg::CONF_INITIAL;
                        r_rptr      <= rptr_next;
                        if (r_count != spt_pkg::CNT_W'(spt_pkg::TABLE_ENTRIES)) begin
                            r_count <= r_count + spt_pkg::CNT_W'(1);
                        end
                    end
                    default: begin
                        r_state_out <= spt_pkg::CONF_INITIAL;
                    end
                endcase
            end
        end
    end

    assign o_result_valid     = r_out_valid;
    assign o_prefetch_pending = r_pend_flag;
    assign o_prefetch_address = r_pend_addr;
    assign o_entry_state      = r_state_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spt_pkg::CNT_W'(spt_pkg::TABLE_ENTRIES))
        else $error("fill count exceeds table size");

    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != spt_pkg::CNT_W'(spt_pkg::TABLE_ENTRIES) |->
            spt_pkg::CNT_W'(r_rptr) == r_count)
        else $error("replace pointer left the fill position before the table filled");

    a_read_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> spt_pkg::CNT_W'(r_idx) < r_count)
        else $error("scan read an entry that was never written");

    a_result_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("result strobe lasted more than one cycle");

    a_steady_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && i_cmd.op == spt_pkg::OP_HIT && hit_conf == spt_pkg::CONF_STEADY
            |=> r_pend_flag)
        else $error("steady hit did not leave a prefetch pending");

endmodule

`default_nettype wire

### src/stride_prefetch_table_unit.sv
// Top level of the stride prefetch table: controller plus datapath.
// A transfer is taken when start is high and busy is low; the result is shown for one cycle
// with o_result_valid and cannot be stalled. A completion command, or a demand access while
// the table is empty, goes from idle straight to the write state, and its result is strobed
// from the result register after that. Any other demand access scans the valid entries in
// order through the single read port of the entry RAM, a request state and a compare state
// per entry examined, until the hit or the end of the filled part, and then writes. A new transfer
// may be taken in the cycle in which the previous result is strobed. No clearing pass is
// needed after reset. o_prefetch_pending and o_prefetch_address show the pending request
// at all times.
`default_nettype none

module stride_prefetch_table_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_command,
    input  wire logic [31:0] i_access_address,
    output logic             o_result_valid,
    output logic             o_prefetch_pending,
    output logic [31:0]      o_prefetch_address,
    output logic [1:0]       o_entry_state
);

    spt_pkg::t_ctrl_cmd  ctrl_cmd;
    spt_pkg::t_dp_status dp_status;

    spt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (dp_status),
        .o_cmd    (ctrl_cmd)
    );

    spt_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_command          (i_command),
        .i_access_address   (i_access_address),
        .i_cmd              (ctrl_cmd),
        .o_status           (dp_status),
        .o_result_valid     (o_result_valid),
        .o_prefetch_pending (o_prefetch_pending),
        .o_prefetch_address (o_prefetch_address),
        .o_entry_state      (o_entry_state)
    );

endmodule

`default_nettype wire
